### sv/psqrl_pkg.sv
// Package: constants, types and state codes for the per-source query rate limiter.
package psqrl_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int OCC_W = IDX_W + 1;
	localparam int PRUNE_ABOVE = 512;
	localparam int PRUNE_FLOOR = (2 * PRUNE_ABOVE) / 3;

	localparam int WIN_W = 12;
	localparam int RATE_W = 16;
	localparam int FLUSH_W = 17;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W = 16;
	localparam int GCNT_W = 32;
	localparam int LIM_W = RATE_W + WIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PER_IP_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_RATE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLUSH_TIMEOUT = 2'd3;

	typedef struct packed {
		logic [31:0] addr;
		logic [CNT_W-1:0] count;
		logic [31:0] start;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PR_RD,
		ST_PR_CHK,
		ST_BS_TEST,
		ST_BS_CHK,
		ST_HIT_CHK,
		ST_MISS,
		ST_SH_RD,
		ST_SH_WR,
		ST_GLOB,
		ST_DONE
	} state_t;

endpackage

### sv/psqrl_if.sv
// Interfaces: query request channel and verdict channel.
interface psqrl_query_if;
	logic valid;
	logic ready;
	logic [31:0] source_ip;
	logic [31:0] now_seconds;
	modport source (output valid, source_ip, now_seconds, input ready);
	modport sink (input valid, source_ip, now_seconds, output ready);
endinterface

interface psqrl_verdict_if;
	logic valid;
	logic ready;
	logic allowed;
	logic untracked;
	modport source (output valid, allowed, untracked, input ready);
	modport sink (input valid, allowed, untracked, output ready);
endinterface

### sv/per_source_query_rate_limiter.sv
// Top level: per-source fixed-window query rate limiter over a sorted address table.
// One request at a time. A request runs a binary search over the table memory and, when a new
// address is inserted, shifts up each entry that lies above the insertion point; a request
// that finds more than PRUNE_ABOVE entries first sweeps the whole table. The table memory
// has a registered read. A finished verdict sits in an output register until taken.
module per_source_query_rate_limiter (
	input logic clk,
	input logic arst_n,
	psqrl_query_if.sink query,
	psqrl_verdict_if.source verdict,
	input logic cfg_we,
	input logic [psqrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [psqrl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import psqrl_pkg::*;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;
	logic mem_re;
	logic [IDX_W-1:0] raddr;
	logic mem_we;
	logic [IDX_W-1:0] waddr;
	entry_t wdata;

	state_t state_q, state_d;

	logic [WIN_W-1:0] window_q;
	logic [RATE_W-1:0] pip_rate_q, g_rate_q;
	logic [FLUSH_W-1:0] flush_q;
	logic [LIM_W-1:0] pip_lim_q, g_lim_q;

	logic [31:0] ip_q, now_q;
	logic [OCC_W-1:0] occ_q, r_q, w_q, live_q, lo_q, hi_q, mid_q, k_q;
	logic [GCNT_W-1:0] gcount_q;
	logic [31:0] gstart_q;
	logic untracked_q, res_allowed_q, res_untracked_q;
	logic out_valid_q, out_allowed_q, out_untracked_q;

	logic [OCC_W:0] mid_sum;
	logic [OCC_W-1:0] mid;
	logic [31:0] idle_d, age_d, gage_d;
	logic drop;
	logic [CNT_W-1:0] cnt_inc;
	logic [GCNT_W-1:0] gcnt_inc;
	logic hit;
	logic deny_ip;
	logic g_ok;

	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid = mid_sum[OCC_W:1];
		idle_d = now_q - rd_q.start;
		age_d = now_q - rd_q.start;
		gage_d = now_q - gstart_q;
		drop = (live_q >= OCC_W'(PRUNE_FLOOR)) && (idle_d > 32'(flush_q)) && (rd_q.addr != ip_q);
		cnt_inc = (rd_q.count != '1) ? rd_q.count + CNT_W'(1) : rd_q.count;
		gcnt_inc = (gcount_q != '1) ? gcount_q + GCNT_W'(1) : gcount_q;
		hit = (rd_q.addr == ip_q);
		deny_ip = (LIM_W'({cnt_inc, 4'b0}) > pip_lim_q);
		g_ok = ({gcnt_inc, 4'b0} <= (GCNT_W+4)'(g_lim_q));
	end

	always_comb begin
		state_d = state_q;
		mem_re = 1'b0;
		raddr = '0;
		mem_we = 1'b0;
		waddr = '0;
		wdata = rd_q;
		query.ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (query.valid) begin
					state_d = (occ_q > OCC_W'(PRUNE_ABOVE)) ? ST_PR_RD : ST_BS_TEST;
				end
			end
			ST_PR_RD: begin
				if (r_q == occ_q) begin
					state_d = ST_BS_TEST;
				end else begin
					mem_re = 1'b1;
					raddr = r_q[IDX_W-1:0];
					state_d = ST_PR_CHK;
				end
			end
			ST_PR_CHK: begin
				if (!drop) begin
					mem_we = 1'b1;
					waddr = w_q[IDX_W-1:0];
					wdata = rd_q;
				end
				state_d = ST_PR_RD;
			end
			ST_BS_TEST: begin
				if (lo_q < hi_q) begin
					mem_re = 1'b1;
					raddr = mid[IDX_W-1:0];
					state_d = ST_BS_CHK;
				end else if (lo_q < occ_q) begin
					mem_re = 1'b1;
					raddr = lo_q[IDX_W-1:0];
					state_d = ST_HIT_CHK;
				end else begin
					state_d = ST_MISS;
				end
			end
			ST_BS_CHK: state_d = ST_BS_TEST;
			ST_HIT_CHK: begin
				if (hit) begin
					mem_we = 1'b1;
					waddr = lo_q[IDX_W-1:0];
					if (age_d > 32'(window_q)) begin
						wdata = '{addr: ip_q, count: CNT_W'(1), start: now_q};
						state_d = ST_GLOB;
					end else begin
						wdata = '{addr: rd_q.addr, count: cnt_inc, start: rd_q.start};
						state_d = deny_ip ? ST_DONE : ST_GLOB;
					end
				end else begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				state_d = (occ_q < OCC_W'(TABLE_DEPTH)) ? ST_SH_RD : ST_GLOB;
			end
			ST_SH_RD: begin
				if (k_q > lo_q) begin
					mem_re = 1'b1;
					raddr = IDX_W'(k_q - OCC_W'(1));
					state_d = ST_SH_WR;
				end else begin
					mem_we = 1'b1;
					waddr = lo_q[IDX_W-1:0];
					wdata = '{addr: ip_q, count: CNT_W'(1), start: now_q};
					state_d = ST_GLOB;
				end
			end
			ST_SH_WR: begin
				mem_we = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rd_q;
				state_d = ST_SH_RD;
			end
			ST_GLOB: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || verdict.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_W'(60);
			pip_rate_q <= RATE_W'(48);
			g_rate_q <= RATE_W'(480);
			flush_q <= FLUSH_W'(120);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SECONDS: window_q <= cfg_wdata[WIN_W-1:0];
				REG_PER_IP_RATE: pip_rate_q <= cfg_wdata[RATE_W-1:0];
				REG_GLOBAL_RATE: g_rate_q <= cfg_wdata[RATE_W-1:0];
				REG_FLUSH_TIMEOUT: flush_q <= cfg_wdata[FLUSH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pip_lim_q <= LIM_W'(pip_rate_q) * LIM_W'(window_q);
		g_lim_q <= LIM_W'(g_rate_q) * LIM_W'(window_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			gcount_q <= '0;
			gstart_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || verdict.ready)) begin
				out_valid_q <= 1'b1;
			end else if (verdict.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_PR_RD: begin
					if (r_q == occ_q) begin
						occ_q <= w_q;
					end
				end
				ST_SH_RD: begin
					if (k_q <= lo_q) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
				ST_GLOB: begin
					if (gage_d <= 32'(window_q)) begin
						gcount_q <= gcnt_inc;
					end else begin
						gcount_q <= GCNT_W'(1);
						gstart_q <= now_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ip_q <= query.source_ip;
				now_q <= query.now_seconds;
				r_q <= '0;
				w_q <= '0;
				live_q <= occ_q;
				lo_q <= '0;
				hi_q <= occ_q;
				untracked_q <= 1'b0;
				res_allowed_q <= 1'b0;
				res_untracked_q <= 1'b0;
			end
			ST_PR_RD: begin
				if (r_q == occ_q) begin
					hi_q <= w_q;
				end
			end
			ST_PR_CHK: begin
				r_q <= r_q + OCC_W'(1);
				if (drop) begin
					live_q <= live_q - OCC_W'(1);
				end else begin
					w_q <= w_q + OCC_W'(1);
				end
			end
			ST_BS_TEST: mid_q <= mid;
			ST_BS_CHK: begin
				if (rd_q.addr < ip_q) begin
					lo_q <= mid_q + OCC_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_HIT_CHK: begin
				res_allowed_q <= 1'b0;
				res_untracked_q <= 1'b0;
			end
			ST_MISS: begin
				k_q <= occ_q;
				untracked_q <= (occ_q >= OCC_W'(TABLE_DEPTH));
			end
			ST_SH_WR: k_q <= k_q - OCC_W'(1);
			ST_GLOB: begin
				res_allowed_q <= (gage_d <= 32'(window_q)) ? g_ok : 1'b1;
				res_untracked_q <= untracked_q;
			end
			ST_DONE: begin
				if (!out_valid_q || verdict.ready) begin
					out_allowed_q <= res_allowed_q;
					out_untracked_q <= res_untracked_q;
				end
			end
			default: ;
		endcase
	end

	assign verdict.valid = out_valid_q;
	assign verdict.allowed = out_allowed_q;
	assign verdict.untracked = out_untracked_q;

endmodule

### tb/tb.sv
// Testbench for the per-source query rate limiter: random and directed requests, checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import psqrl_pkg::*;

	typedef struct {
		bit allowed;
		bit untracked;
	} verdict_t;

	typedef struct {
		bit [31:0] addr;
		bit [15:0] count;
		bit [31:0] start;
	} slot_t;

	class verdict_scoreboard;
		bit [WIN_W-1:0] window_s;
		bit [RATE_W-1:0] ip_rate;
		bit [RATE_W-1:0] glob_rate;
		bit [FLUSH_W-1:0] flush_s;
		slot_t table_q[$];
		bit [31:0] glob_count;
		bit [31:0] glob_start;
		verdict_t pending[$];
		int errors;
		int mismatches;

		function new();
			window_s = 60;
			ip_rate = 48;
			glob_rate = 480;
			flush_s = 120;
			glob_count = 0;
			glob_start = 0;
			errors = 0;
			mismatches = 0;
		endfunction

		function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] d);
			case (idx)
				REG_WINDOW_SECONDS: window_s = d[WIN_W-1:0];
				REG_PER_IP_RATE: ip_rate = d[RATE_W-1:0];
				REG_GLOBAL_RATE: glob_rate = d[RATE_W-1:0];
				REG_FLUSH_TIMEOUT: flush_s = d[FLUSH_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_query(bit [31:0] ip, bit [31:0] now);
			slot_t kept[$];
			slot_t e;
			int live;
			int pos;
			bit [31:0] idle;
			verdict_t r;
			r.allowed = 0;
			r.untracked = 0;
			if (table_q.size() > PRUNE_ABOVE) begin
				live = table_q.size();
				foreach (table_q[i]) begin
					idle = now - table_q[i].start;
					if (live >= PRUNE_FLOOR && idle > flush_s && table_q[i].addr != ip)
						live--;
					else
						kept.push_back(table_q[i]);
				end
				table_q = kept;
			end
			pos = 0;
			while (pos < table_q.size() && table_q[pos].addr < ip)
				pos++;
			if (pos < table_q.size() && table_q[pos].addr == ip) begin
				if (table_q[pos].count != 16'hFFFF)
					table_q[pos].count++;
				idle = now - table_q[pos].start;
				if (idle > window_s) begin
					table_q[pos].start = now;
					table_q[pos].count = 1;
				end else if (64'(table_q[pos].count) * 16 > 64'(ip_rate) * 64'(window_s)) begin
					pending.push_back(r);
					return;
				end
			end else if (table_q.size() < TABLE_DEPTH) begin
				e.addr = ip;
				e.count = 1;
				e.start = now;
				table_q.insert(pos, e);
			end else begin
				r.untracked = 1;
			end
			if (glob_count != 32'hFFFFFFFF)
				glob_count++;
			idle = now - glob_start;
			if (idle <= window_s) begin
				r.allowed = 64'(glob_count) * 16 <= 64'(glob_rate) * 64'(window_s);
			end else begin
				glob_count = 1;
				glob_start = now;
				r.allowed = 1;
			end
			pending.push_back(r);
		endfunction

		function void check_verdict(bit allowed, bit untracked);
			verdict_t x;
			if (pending.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("verdict with none expected: allowed=%0b untracked=%0b",
						allowed, untracked);
				return;
			end
			x = pending.pop_front();
			if (x.allowed != allowed || x.untracked != untracked) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("verdict mismatch: expected allowed=%0b untracked=%0b, got %0b %0b",
						x.allowed, x.untracked, allowed, untracked);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	psqrl_query_if query();
	psqrl_verdict_if verdict();

	per_source_query_rate_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query.sink),
		.verdict(verdict.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	verdict_scoreboard sb;
	bit quiet;
	int stall_left;
	bit [31:0] now_s;
	bit [31:0] pool[12];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (verdict.valid && verdict.ready)
				sb.check_verdict(verdict.allowed, verdict.untracked);
			if (stall_left > 0) begin
				verdict.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				verdict.ready <= quiet || ($urandom_range(99) >= 11);
			end
		end
	end

	task automatic set_config(bit [11:0] w, bit [15:0] pr, bit [15:0] gr, bit [16:0] fl);
		bit [CFG_DATA_W-1:0] vals[4];
		vals[0] = CFG_DATA_W'(w);
		vals[1] = CFG_DATA_W'(pr);
		vals[2] = CFG_DATA_W'(gr);
		vals[3] = fl;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.write_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_query(bit [31:0] ip, bit [31:0] t);
		if (!quiet && $urandom_range(99) < 11) begin
			query.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		query.valid <= 1'b1;
		query.source_ip <= ip;
		query.now_seconds <= t;
		do @(posedge clk); while (!query.ready);
		sb.note_query(ip, t);
	endtask

	task automatic drain();
		query.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic random_query();
		bit [31:0] ip;
		if ($urandom_range(99) < 75)
			ip = pool[$urandom_range(11)];
		else
			ip = $urandom;
		if ($urandom_range(99) < 5)
			now_s = $urandom;
		else
			now_s = now_s + $urandom_range(0, 2);
		send_query(ip, now_s);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		query.valid = 1'b0;
		query.source_ip = '0;
		query.now_seconds = '0;
		verdict.ready = 1'b0;
		quiet = 0;
		stall_left = 0;
		for (int i = 0; i < 12; i++)
			pool[i] = (i < 6) ? 32'h0A000000 + i : $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults first
		send_query(32'h00000000, 32'd1000);
		send_query(32'hFFFFFFFF, 32'd1000);
		send_query(32'h00000000, 32'd1001);
		drain();

		set_config(12'd2, 16'd16, 16'd65535, 17'd120);
		repeat (4) send_query(32'h12345678, 32'd2000);
		send_query(32'h12345678, 32'd2003);
		send_query(32'h55555555, 32'hFFFFFFFF);
		send_query(32'h55555555, 32'd1);
		send_query(32'h55555555, 32'd1);
		send_query(32'h55555555, 32'd1);
		drain();

		set_config(12'd0, 16'd65535, 16'd65535, 17'd0);
		send_query(32'hAAAAAAAA, 32'd5000);
		send_query(32'hAAAAAAAA, 32'd5000);
		send_query(32'hAAAAAAAA, 32'd5001);
		drain();

		set_config(12'd4095, 16'd0, 16'd0, 17'd131071);
		send_query(32'hAAAAAAAA, 32'd6000);
		send_query(32'hAAAAAAAA, 32'd6001);
		send_query(32'h0000FFFF, 32'd6001);
		send_query(32'h0000FFFF, 32'd6002);
		drain();

		now_s = 32'd100000;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(12'd1, 16'd16, 16'd32, 17'd0);
				1: set_config(12'd4095, 16'd65535, 16'd65535, 17'd131071);
				2: set_config(12'd10, 16'd20, 16'd200, 17'd5);
				3: set_config(12'd0, 16'd0, 16'd0, 17'd0);
				4: set_config(12'd60, 16'd48, 16'd480, 17'd120);
				default: set_config(12'd3, 16'd40, 16'd100, 17'd30);
			endcase
			quiet = (ph == 2);
			for (int i = 0; i < 65; i++) begin
				if (ph == 4 && i == 20)
					stall_left = 300;
				random_query();
			end
			drain();
		end
		quiet = 0;

		// short window and timeout after a jump in time
		set_config(12'd5, 16'd32, 16'd400, 17'd10);
		now_s = now_s + 100;
		for (int i = 0; i < 40; i++)
			random_query();
		drain();

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
